### hw/rtl/srl_pkg.sv
// srl_pkg: shared types and constants for the sample ring lookup block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package srl_pkg;
  localparam logic [1:0] OP_OFFER = 2'd0;
  localparam logic [1:0] OP_ID_AT_TIME = 2'd1;
  localparam logic [1:0] OP_TIME_OF_ID = 2'd2;
  localparam int unsigned IntervalW = 27;
  localparam logic [9:0] MS_TO_US = 10'd1000;
  localparam logic [IntervalW-1:0] INTERVAL_RESET = 27'd1000;
  localparam logic [0:0] REG_INTERVAL = 1'b0;
endpackage
`default_nettype wire

### hw/rtl/srl_scale.sv
// srl_scale: iterative floor(span * part / whole), part < whole
// multiplies in four 32x32 steps, then restoring division one bit a cycle; uses srl_pkg
`timescale 1ns / 1ps
`default_nettype none
module srl_scale
  import srl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] span_i,
  input  wire logic [63:0] part_i,
  input  wire logic [63:0] whole_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_e;
  state_e state_q;
  logic [63:0] a_q, b_q, w_q, rem_q, lo_q, quo_q;
  logic [127:0] prod_q;
  logic [2:0] mstep_q;
  logic [5:0] bit_q;
  logic [31:0] ma, mb;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  logic [64:0] rem_sh;
  logic sub;

  always_comb begin
    ma = mstep_q[0] ? a_q[63:32] : a_q[31:0];
    mb = mstep_q[1] ? b_q[63:32] : b_q[31:0];
    pp = ma * mb;
    pp_sh = {64'd0, pp} << (7'd32 * ({6'd0, mstep_q[0]} + {6'd0, mstep_q[1]}));
    rem_sh = {rem_q, lo_q[63]};
    sub = rem_sh >= {1'b0, w_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o <= 1'b0;
      mstep_q <= '0;
      bit_q <= '0;
    end else begin
      done_o <= state_q == S_DIV && bit_q == 6'd0;
      unique case (state_q)
        S_IDLE: if (start_i) begin
          a_q <= span_i; b_q <= part_i; w_q <= whole_i;
          prod_q <= '0; mstep_q <= '0; state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q <= prod_q + pp_sh;
          mstep_q <= mstep_q + 3'd1;
          if (mstep_q == 3'd3) begin
            state_q <= S_DIV;
            bit_q <= 6'd63;
            quo_q <= '0;
            // dividend high half seeds the remainder, low half is shifted in
            rem_q <= prod_q[127:64] + pp_sh[127:64] +
                     {63'd0, ({1'b0, prod_q[63:0]} + {1'b0, pp_sh[63:0]}) >> 64 != 65'd0};
            lo_q <= prod_q[63:0] + pp_sh[63:0];
          end
        end
        S_DIV: begin
          rem_q <= sub ? 64'(rem_sh - {1'b0, w_q}) : rem_sh[63:0];
          lo_q <= {lo_q[62:0], 1'b0};
          quo_q <= {quo_q[62:0], sub};
          bit_q <= bit_q - 6'd1;
          if (bit_q == 6'd0) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
  assign quo_o = quo_q;
endmodule
`default_nettype wire

### hw/rtl/sample_ring_interpolating_lookup_top.sv
// sample_ring_interpolating_lookup_top: ring of (id, time) samples with
// interpolating lookup; uses srl_pkg and srl_scale
`timescale 1ns / 1ps
`default_nettype none
// An offer is decided as it is taken, its result registered in the next cycle;
// the next item is taken only after the result has been accepted. A query reads
// the ring from the oldest stored sample one entry a cycle through a synchronous
// memory read, and when interpolation is needed goes on to the shared
// multiply/divide unit (four 32x32 product steps, 64 division steps and a
// registered done flag).
// One item is handled at a time; the result sits in an output register.
module sample_ring_interpolating_lookup_top
  import srl_pkg::*;
#(
  parameter int unsigned CAPACITY = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [63:0] id_value_i,
  input  wire logic [63:0] time_value_i,
  input  wire logic [63:0] live_id_i,
  input  wire logic [63:0] live_time_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             done_res_o,
  output logic [63:0]      result_id_o,
  output logic [63:0]      result_time_o
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LIVE, S_PICK, S_DIV} state_e;
  state_e state_q;

  logic [IntervalW-1:0] interval_q;
  logic [AW-1:0] wslot_q, rd_addr_q;
  logic [CW-1:0] fill_q, k_q;
  logic [63:0] last_q;
  logic [1:0] op_q;
  logic [63:0] tid_q, tt_q, lid_q, lt_q;
  logic [63:0] lo_id_q, lo_t_q, hi_id_q, hi_t_q;
  logic first_q;

  logic [63:0] mem_id [CAPACITY];
  logic [63:0] mem_t [CAPACITY];
  logic [63:0] rd_id_q, rd_t_q;
  logic        we;
  logic [AW-1:0] wa, ra, ra_inc;
  logic [63:0] wd_id, wd_t;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_id[wa] <= wd_id;
      mem_t[wa]  <= wd_t;
    end
    rd_id_q <= mem_id[ra];
    rd_t_q  <= mem_t[ra];
  end

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == {1'b0, REG_INTERVAL}) ? {5'd0, interval_q} : 32'd0;
  wire cfg_we = psel && penable && pwrite && paddr == {1'b0, REG_INTERVAL};

  // offer decision
  logic [63:0] tv_adj, diff;
  logic [36:0] need;
  logic due;
  always_comb begin
    need = 37'(interval_q) * 37'(MS_TO_US);
    diff = time_value_i - last_q;
    due = interval_q == '0 || last_q == '0 || $signed(time_value_i) < $signed(last_q)
          || diff >= {27'd0, need};
    tv_adj = ($signed(time_value_i) < $signed(last_q)) ? last_q : time_value_i;
  end

  wire acc = in_valid_i && in_ready_o;
  assign in_ready_o = state_q == S_IDLE && !out_valid_o;
  assign we = acc && opcode_i == OP_OFFER && due;
  assign wa = wslot_q;
  assign wd_id = id_value_i;
  assign wd_t = tv_adj;
  logic [AW-1:0] oldest;
  assign oldest = (CW'(wslot_q) >= fill_q) ? AW'(CW'(wslot_q) - fill_q)
                : AW'((CW+1)'(wslot_q) + (CW+1)'(CAPACITY) - (CW+1)'(fill_q));
  assign ra = (state_q == S_IDLE) ? oldest : rd_addr_q;
  assign ra_inc = (ra == AW'(CAPACITY - 1)) ? '0 : ra + AW'(1);

  // comparisons on the entry just read
  logic by_time, le_cur, lt_first, live_ok;
  logic [63:0] live_t_eff;
  always_comb begin
    by_time = op_q == OP_ID_AT_TIME;
    le_cur = by_time ? ($signed(tt_q) <= $signed(rd_t_q)) : (tid_q <= rd_id_q);
    lt_first = by_time ? ($signed(tt_q) < $signed(rd_t_q)) : (tid_q < rd_id_q);
    live_t_eff = ($signed(lt_q) < $signed(lo_t_q)) ? lo_t_q : lt_q;
    live_ok = by_time ? ($signed(tt_q) <= $signed(live_t_eff)) : (tid_q <= lid_q);
  end

  // interpolation decision
  logic easy;
  logic [63:0] easy_val, span, part, whole;
  always_comb begin
    easy = 1'b1; easy_val = '0; span = '0; part = '0; whole = '0;
    if (by_time) begin
      if ($signed(tt_q) <= $signed(lo_t_q) || hi_id_q <= lo_id_q) easy_val = lo_id_q;
      else if ($signed(tt_q) >= $signed(hi_t_q)) easy_val = hi_id_q;
      else if ($signed(hi_t_q) <= $signed(lo_t_q)) easy_val = lo_id_q;
      else easy = 1'b0;
      span = hi_id_q - lo_id_q; part = tt_q - lo_t_q; whole = hi_t_q - lo_t_q;
    end else begin
      if (tid_q <= lo_id_q || hi_id_q <= lo_id_q) easy_val = lo_t_q;
      else if (tid_q >= hi_id_q) easy_val = hi_t_q;
      else if ($signed(hi_t_q) <= $signed(lo_t_q)) easy_val = lo_t_q;
      else easy = 1'b0;
      span = hi_t_q - lo_t_q; part = tid_q - lo_id_q; whole = hi_id_q - lo_id_q;
    end
  end

  logic dv_start, dv_done;
  logic [63:0] quo;
  assign dv_start = state_q == S_PICK && !easy;
  srl_scale u_scale (
    .clk_i, .rst_ni, .start_i(dv_start), .span_i(span), .part_i(part),
    .whole_i(whole), .done_o(dv_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      interval_q <= INTERVAL_RESET;
      wslot_q <= '0;
      fill_q <= '0;
      last_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we) interval_q <= pwdata[IntervalW-1:0];
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (acc) begin
          op_q <= opcode_i; tid_q <= id_value_i; tt_q <= time_value_i;
          lid_q <= live_id_i; lt_q <= live_time_i;
          done_res_o <= 1'b0; result_id_o <= '0; result_time_o <= '0;
          rd_addr_q <= ra_inc;
          k_q <= CW'(1); first_q <= 1'b1;
          if (opcode_i == OP_OFFER) begin
            out_valid_o <= 1'b1;
            if (due) begin
              done_res_o <= 1'b1; result_time_o <= tv_adj; last_q <= tv_adj;
              wslot_q <= (wslot_q == AW'(CAPACITY - 1)) ? '0 : wslot_q + AW'(1);
              if (fill_q != CW'(CAPACITY)) fill_q <= fill_q + CW'(1);
            end
          end else if (opcode_i == OP_ID_AT_TIME || opcode_i == OP_TIME_OF_ID) begin
            if (fill_q == '0) out_valid_o <= 1'b1;
            else state_q <= S_SCAN;
          end else out_valid_o <= 1'b1;
        end
        S_SCAN: begin
          // rd_*_q holds entry k-1 of the ring (oldest first)
          if (first_q && lt_first) begin
            out_valid_o <= 1'b1; state_q <= S_IDLE;
          end else if (!first_q && le_cur) begin
            hi_id_q <= rd_id_q; hi_t_q <= rd_t_q; state_q <= S_PICK;
          end else begin
            lo_id_q <= rd_id_q; lo_t_q <= rd_t_q;
            if (k_q == fill_q) state_q <= S_LIVE;
          end
          first_q <= 1'b0;
          k_q <= k_q + CW'(1);
          rd_addr_q <= ra_inc;
        end
        S_LIVE: begin
          if (live_ok) begin
            hi_id_q <= lid_q; hi_t_q <= live_t_eff; state_q <= S_PICK;
          end else begin
            out_valid_o <= 1'b1; state_q <= S_IDLE;
          end
        end
        S_PICK: begin
          done_res_o <= 1'b1;
          if (easy) begin
            if (by_time) result_id_o <= easy_val; else result_time_o <= easy_val;
            out_valid_o <= 1'b1; state_q <= S_IDLE;
          end else state_q <= S_DIV;
        end
        S_DIV: if (dv_done) begin
          if (by_time) result_id_o <= lo_id_q + quo;
          else result_time_o <= lo_t_q + quo;
          out_valid_o <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY)) else $error("fill count beyond capacity");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("item taken while busy");
  a_write_only_offer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> out_valid_o && done_res_o) else $error("stored sample not reported");
endmodule
`default_nettype wire

### test/sample_ring_interpolating_lookup_top_tb.sv
// testbench for sample_ring_interpolating_lookup_top: offers and queries with random
// idling, checked item by item against a behavioural predictor; uses srl_pkg
`timescale 1ns / 1ps
module sample_ring_interpolating_lookup_top_tb;
  import srl_pkg::*;

  localparam int unsigned DEPTH = 8192;
  localparam int CAPACITY_SLACK = 100;

  typedef struct packed {
    logic        done;
    logic [63:0] rid;
    logic [63:0] rtime;
  } lookup_res_t;

  // ring predictor and queue of expected lookup results
  class ring_scoreboard;
    logic [63:0] ids[DEPTH];
    logic [63:0] times[DEPTH];
    int unsigned wslot;
    int unsigned fill;
    logic signed [63:0] last_t;
    logic [26:0] interval;
    lookup_res_t pending[$];
    int errors;

    function new();
      wslot = 0; fill = 0; last_t = 0; interval = INTERVAL_RESET; errors = 0;
    endfunction

    function logic [63:0] scaled(logic [63:0] span, logic [63:0] part,
                                 logic [63:0] whole);
      logic [127:0] prod;
      prod = {64'd0, span} * {64'd0, part};
      return 64'(prod / {64'd0, whole});
    endfunction

    function bit bracket(bit by_time, logic signed [63:0] tt, logic [63:0] it,
                         logic [63:0] lid, logic signed [63:0] lt,
                         output logic [63:0] lo_i, output logic signed [63:0] lo_t,
                         output logic [63:0] hi_i, output logic signed [63:0] hi_t);
      int unsigned old, k, ix;
      logic [63:0] pi;
      logic signed [63:0] pt;
      lo_i = 0; lo_t = 0; hi_i = 0; hi_t = 0;
      if (fill == 0) return 0;
      old = (wslot + DEPTH - fill) % DEPTH;
      pi = ids[old]; pt = times[old];
      if (by_time ? (tt < pt) : (it < pi)) return 0;
      for (k = 1; k < fill; k++) begin
        ix = (old + k) % DEPTH;
        if (by_time ? (tt <= $signed(times[ix])) : (it <= ids[ix])) begin
          lo_i = pi; lo_t = pt; hi_i = ids[ix]; hi_t = times[ix];
          return 1;
        end
        pi = ids[ix]; pt = times[ix];
      end
      if (lt < pt) lt = pt;
      if (by_time ? (tt <= lt) : (it <= lid)) begin
        lo_i = pi; lo_t = pt; hi_i = lid; hi_t = lt;
        return 1;
      end
      return 0;
    endfunction

    function void note_item(logic [1:0] op, logic [63:0] id, logic signed [63:0] tv,
                            logic [63:0] lid, logic signed [63:0] lt);
      lookup_res_t r;
      logic [63:0] lo_i, hi_i;
      logic signed [63:0] lo_t, hi_t;
      bit due;
      r = '0;
      if (op == OP_OFFER) begin
        due = interval == 0 || last_t == 0 || tv < last_t;
        if (!due) due = 64'(tv - last_t) >= 64'(interval) * 64'(MS_TO_US);
        if (due) begin
          if (tv < last_t) tv = last_t;
          ids[wslot] = id; times[wslot] = tv;
          wslot = (wslot + 1) % DEPTH;
          if (fill < DEPTH) fill++;
          last_t = tv;
          r.done = 1; r.rtime = tv;
        end
      end else if (op == OP_ID_AT_TIME) begin
        if (bracket(1, tv, 0, lid, lt, lo_i, lo_t, hi_i, hi_t)) begin
          r.done = 1;
          if (tv <= lo_t || hi_i <= lo_i) r.rid = lo_i;
          else if (tv >= hi_t) r.rid = hi_i;
          else if (hi_t <= lo_t) r.rid = lo_i;
          else r.rid = lo_i + scaled(hi_i - lo_i, tv - lo_t, hi_t - lo_t);
        end
      end else if (op == OP_TIME_OF_ID) begin
        if (bracket(0, 0, id, lid, lt, lo_i, lo_t, hi_i, hi_t)) begin
          r.done = 1;
          if (id <= lo_i || hi_i <= lo_i) r.rtime = lo_t;
          else if (id >= hi_i) r.rtime = hi_t;
          else if (hi_t <= lo_t) r.rtime = lo_t;
          else r.rtime = lo_t + scaled(hi_t - lo_t, id - lo_i, hi_i - lo_i);
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic d, logic [63:0] rid, logic [63:0] rt);
      lookup_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result done=%0b id=%h time=%h", $time, d, rid, rt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d !== e.done) begin
        $display("%0t: done_res expected %0b actual %0b", $time, e.done, d);
        errors++;
      end
      if (rid !== e.rid) begin
        $display("%0t: result_id expected %h actual %h", $time, e.rid, rid);
        errors++;
      end
      if (rt !== e.rtime) begin
        $display("%0t: result_time expected %h actual %h", $time, e.rtime, rt);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] opcode;
  logic [63:0] id_value, time_value, live_id, live_time;
  logic done_res;
  logic [63:0] result_id, result_time;

  ring_scoreboard sb;
  bit out_stalls = 1;
  int unsigned n_offers, n_queries;

  sample_ring_interpolating_lookup_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .id_value_i(id_value), .time_value_i(time_value),
    .live_id_i(live_id), .live_time_i(live_time),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .done_res_o(done_res), .result_id_o(result_id), .result_time_o(result_time)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("sample_ring_interpolating_lookup_top_tb NOT OK");
    $finish;
  end

  // result side: check on accept, stall in bursts
  initial begin
    int gap;
    out_ready = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(done_res, result_id, result_time);
      if (out_stalls && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        out_ready <= 0;
        repeat (gap) begin
          @(posedge clk);
          if (out_valid && out_ready) sb.check_result(done_res, result_id, result_time);
        end
      end
      out_ready <= 1;
    end
  end

  task automatic write_interval(logic [26:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'({REG_INTERVAL, 2'b00});
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.interval = v;
  endtask

  // valid stays up into the next item unless an idle burst or a drain follows
  task automatic send_item(bit may_idle, logic [1:0] op, logic [63:0] id,
                           logic [63:0] tv, logic [63:0] lid, logic [63:0] lt);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1; opcode <= op; id_value <= id; time_value <= tv;
    live_id <= lid; live_time <= lt;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, id, tv, lid, lt);
    if (op == OP_OFFER) n_offers++; else n_queries++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (CAPACITY_SLACK) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] t, idv, q;
    logic [1:0] op;
    int i, r;
    sb = new();
    rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; opcode = 0; id_value = 0; time_value = 0; live_id = 0; live_time = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty ring queries, opcode 3, offers under default interval
    send_item(0, OP_ID_AT_TIME, 0, 64'd5, 64'd10, 64'd100);
    send_item(0, OP_TIME_OF_ID, 64'd5, 0, 64'd10, 64'd100);
    send_item(0, 2'd3, rand64(), rand64(), rand64(), rand64());
    send_item(0, OP_OFFER, 64'd100, 64'd1000, 0, 0);
    send_item(0, OP_OFFER, 64'd110, 64'd1500, 0, 0);        // refused, too soon
    send_item(0, OP_OFFER, 64'd200, 64'd1001000, 0, 0);
    send_item(0, OP_OFFER, 64'd150, 64'd500, 0, 0);          // older, raised
    send_item(0, OP_OFFER, 64'd400, 64'd3001000, 0, 0);
    send_item(0, OP_ID_AT_TIME, 0, 64'd999, 64'd500, 64'd4000000);  // before oldest
    send_item(0, OP_ID_AT_TIME, 0, 64'd1000, 64'd500, 64'd4000000); // at an end
    send_item(0, OP_ID_AT_TIME, 0, 64'd2000000, 64'd500, 64'd4000000);
    send_item(0, OP_ID_AT_TIME, 0, 64'd3500000, 64'd500, 64'd4000000); // live pair
    send_item(0, OP_ID_AT_TIME, 0, 64'd3500000, 64'd500, 64'd5); // live time raised
    send_item(0, OP_ID_AT_TIME, 0, 64'd9000000, 64'd500, 64'd4000000); // past live
    send_item(0, OP_TIME_OF_ID, 64'd300, 0, 64'd500, 64'd4000000);
    send_item(0, OP_TIME_OF_ID, 64'd450, 0, 64'd500, 64'd4000000);
    send_item(0, OP_TIME_OF_ID, 64'd99, 0, 64'd500, 64'd4000000);
    send_item(0, OP_TIME_OF_ID, 64'hFFFFFFFFFFFFFFFF, 0, 64'hFFFFFFFFFFFFFFFF,
              64'h7FFFFFFFFFFFFFFF);
    send_item(0, OP_TIME_OF_ID, 64'd450, 0, 64'd300, 64'd4000000); // past the live id
    drain();   // hold-off with everything returned

    // extremes of the interval, with full-range times
    write_interval(27'd0);
    send_item(0, OP_OFFER, 64'hFFFFFFFFFFFFFFFF, 64'h7FFFFFFFFFFFFFFF, 0, 0);
    send_item(0, OP_OFFER, 0, 64'h8000000000000000, 0, 0);
    send_item(0, OP_ID_AT_TIME, 0, 64'h7FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
              64'h8000000000000000);
    drain();
    write_interval(27'd86400000);
    send_item(0, OP_OFFER, 64'd1, 64'd1, 0, 0);
    drain();

    // random: mostly monotonic offers with queries inside the span
    write_interval(27'd0);
    t = 64'd1000; idv = 64'd1000;
    for (i = 0; i < 80; i++) begin
      if (i == 45) begin
        drain();
        write_interval(27'($urandom_range(0, 3)));
      end
      if (i == 65) out_stalls = 0;
      r = $urandom_range(0, 9);
      if (r < 4) begin
        t = t + $urandom_range(0, 5000);
        idv = idv + $urandom_range(0, 50);
        send_item(i < 65, OP_OFFER, idv, t, 0, 0);
      end else if (r < 6) begin
        q = t - $urandom_range(0, 200000);
        send_item(i < 65, OP_ID_AT_TIME, rand64(), q, idv + $urandom_range(0, 100),
                  t + $urandom_range(0, 10000));
      end else if (r < 8) begin
        q = idv - $urandom_range(0, 2000);
        send_item(i < 65, OP_TIME_OF_ID, q, rand64(), idv + $urandom_range(0, 100),
                  t + $urandom_range(0, 10000));
      end else begin
        op = 2'($urandom_range(0, 3));
        send_item(i < 65, op, rand64(), rand64(), rand64(), rand64());
        if (op == OP_OFFER && sb.last_t > $signed(t)) t = sb.last_t;
      end
    end
    drain();
    $display("covered %0d offers and %0d queries or ignored items, interval settings 0 to max",
             n_offers, n_queries);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sample_ring_interpolating_lookup_top_tb OK");
    end else begin
      $display("sample_ring_interpolating_lookup_top_tb NOT OK");
    end
    $finish;
  end
endmodule
